>>> hdl/cdadv_pkg.sv
// Package for the calendar date advance core.
// Holds the calendar kind codes, shared constants and the month start table.
// Depends on nothing; every other file of the core imports it.
`default_nettype none
package cdadv_pkg;

   typedef enum logic [2:0] {
      CAL_GREGORIAN = 3'd0,
      CAL_NOLEAP    = 3'd1,
      CAL_ALL_LEAP  = 3'd2,
      CAL_360_DAY   = 3'd3,
      CAL_JULIAN    = 3'd4
   } cal_kind_type;

   localparam int YEAR_BITS_DEFAULT = 14;
   localparam int SECS_PER_DAY      = 86400;
   localparam int SEC_OFFSET_DAYS   = 24856;

   function automatic logic [8:0] month_offset(input logic is360, input logic leap,
                                               input logic [3:0] m);
      logic [8:0] off;
      if (is360) begin
         off = {5'd0, m} * 9'd30;
      end else begin
         case (m)
            4'd0:  off = 9'd0;
            4'd1:  off = 9'd31;
            4'd2:  off = leap ? 9'd60  : 9'd59;
            4'd3:  off = leap ? 9'd91  : 9'd90;
            4'd4:  off = leap ? 9'd121 : 9'd120;
            4'd5:  off = leap ? 9'd152 : 9'd151;
            4'd6:  off = leap ? 9'd182 : 9'd181;
            4'd7:  off = leap ? 9'd213 : 9'd212;
            4'd8:  off = leap ? 9'd244 : 9'd243;
            4'd9:  off = leap ? 9'd274 : 9'd273;
            4'd10: off = leap ? 9'd305 : 9'd304;
            4'd11: off = leap ? 9'd335 : 9'd334;
            4'd12: off = leap ? 9'd366 : 9'd365;
            default: off = 9'd0;
         endcase
      end
      return off;
   endfunction

endpackage
`default_nettype wire

>>> hdl/cdadv_year_days.sv
// Days before a year and the leap flag of that year for the selected calendar.
// Divisions by 100 and 400 use reciprocal multiplication; imports cdadv_pkg.
`default_nettype none
module cdadv_year_days #(
   parameter int YEAR_BITS = cdadv_pkg::YEAR_BITS_DEFAULT
) (
   input  cdadv_pkg::cal_kind_type kind,
   input  logic [YEAR_BITS:0]      year,
   output logic [YEAR_BITS+9:0]    days,
   output logic                    leap
);
   import cdadv_pkg::*;

   localparam int N  = YEAR_BITS + 1;
   localparam int K  = N + 5;
   localparam int DW = YEAR_BITS + 10;
   localparam logic [N:0] M25 = (N+1)'(((64'd1 << K) + 64'd24) / 64'd25);

   function automatic logic [N-1:0] div25(input logic [N-1:0] w);
      logic [2*N:0] p;
      p = (2*N+1)'(w) * (2*N+1)'(M25);
      p = p >> K;
      return p[N-1:0];
   endfunction

   logic [DW-1:0] y_ext;
   logic [DW-1:0] y365;
   logic [DW-1:0] quads;
   logic [N:0]    ya99;
   logic [N:0]    ya399;
   logic [N-1:0]  cent;
   logic [N-1:0]  quad_cent;
   logic [DW-1:0] cent_ext;
   logic [DW-1:0] quad_cent_ext;

   assign y_ext         = {9'd0, year};
   assign y365          = y_ext * DW'(365);
   assign quads         = (y_ext + DW'(3)) >> 2;
   assign ya99          = {1'b0, year} + (N+1)'(99);
   assign ya399         = {1'b0, year} + (N+1)'(399);
   assign cent          = div25(N'(ya99 >> 2));
   assign quad_cent     = div25(N'(ya399 >> 4));
   assign cent_ext      = {9'd0, cent};
   assign quad_cent_ext = {9'd0, quad_cent};

   always_comb begin
      case (kind)
         CAL_GREGORIAN: begin
            days = y365 + quads - cent_ext + quad_cent_ext;
            leap = (year[1:0] == 2'd0) &&
                   ((cent_ext * DW'(100) != y_ext) || (quad_cent_ext * DW'(400) == y_ext));
         end
         CAL_ALL_LEAP: begin
            days = y_ext * DW'(366);
            leap = 1'b1;
         end
         CAL_360_DAY: begin
            days = y_ext * DW'(360);
            leap = 1'b0;
         end
         CAL_JULIAN: begin
            days = y365 + quads;
            leap = (year[1:0] == 2'd0);
         end
         default: begin
            days = y365;
            leap = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/cdadv_month_split.sv
// Splits a day of year into a zero-based month and day of month.
// Uses the month start table of cdadv_pkg.
`default_nettype none
module cdadv_month_split (
   input  logic       is360,
   input  logic       leap,
   input  logic [8:0] doy,
   output logic [3:0] month,
   output logic [4:0] day
);
   import cdadv_pkg::*;

   logic [10:0] passed;
   logic [8:0]  start;

   always_comb begin
      for (int i = 0; i < 11; i++) begin
         passed[i] = month_offset(is360, leap, 4'(i + 1)) <= doy;
      end
   end

   assign month = 4'($countones(passed));
   assign start = month_offset(is360, leap, month);
   assign day   = 5'(doy - start);

endmodule
`default_nettype wire

>>> hdl/calendar_date_advance_core.sv
// Calendar date advance core: adds day and second offsets to a date.
// rsp_tvalid rises when the accepted request item reaches the last of the eight stages;
// one item per cycle is accepted while rsp_tready does not hold the pipeline, with per-stage flow control.
// Reset is synchronous active high; it clears the valid bits and sets the
// calendar kind to Gregorian. Depends on cdadv_pkg and both submodules.
`default_nettype none
module calendar_date_advance_core #(
   parameter int YEAR_BITS = cdadv_pkg::YEAR_BITS_DEFAULT,
   parameter int REQ_W     = ((YEAR_BITS + 82 + 7) / 8) * 8,
   parameter int RSP_W     = ((YEAR_BITS + 26 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // year_in, month_in, day_in, second_in, delta_days, delta_seconds
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // year_out, month_out, day_out, second_out
   output logic [RSP_W-1:0] rsp_tdata,
   // out_of_range
   output logic             rsp_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_data
);
   import cdadv_pkg::*;

   localparam int Y     = YEAR_BITS;
   localparam int DW    = Y + 10;
   localparam int ABS_W = ((Y + 10 > 25) ? Y + 10 : 25) + 1;
   localparam int SH    = Y + 15;
   localparam int RW    = Y + 8;
   localparam logic [63:0] YE = 64'd1 << Y;
   localparam logic [63:0] END_GREG = 64'd365 * YE + (YE + 64'd3) / 64'd4
                                    - (YE + 64'd99) / 64'd100 + (YE + 64'd399) / 64'd400;
   localparam logic [63:0] END_JUL  = 64'd365 * YE + (YE + 64'd3) / 64'd4;
   localparam logic [63:0] END_365  = 64'd365 * YE;
   localparam logic [63:0] END_366  = 64'd366 * YE;
   localparam logic [63:0] END_360  = 64'd360 * YE;
   localparam logic [63:0] RCP_GREG = ((64'd1 << SH) * 64'd400) / 64'd146097;
   localparam logic [63:0] RCP_JUL  = ((64'd1 << SH) * 64'd4) / 64'd1461;
   localparam logic [63:0] RCP_365  = (64'd1 << SH) / 64'd365;
   localparam logic [63:0] RCP_366  = (64'd1 << SH) / 64'd366;
   localparam logic [63:0] RCP_360  = (64'd1 << SH) / 64'd360;
   localparam logic [32:0] SEC_BIAS = 33'(SEC_OFFSET_DAYS) * 33'(SECS_PER_DAY);
   localparam logic [26:0] M675     = 27'd101806632;

   typedef struct packed {
      logic [Y-1:0] year;
      logic [3:0]   month;
      logic [4:0]   day;
      logic [16:0]  sec;
   } echo_type;

   cal_kind_type kind_ff;
   logic         is360;

   assign csr_ready = 1'b1;
   assign is360     = (kind_ff == CAL_360_DAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= CAL_GREGORIAN;
      end else if (csr_valid && csr_data <= 3'(CAL_JULIAN)) begin
         kind_ff <= cal_kind_type'(csr_data);
      end
   end

   logic [8:1] v_ff;
   logic [8:1] adv;
   echo_type   echo_ff [1:8];

   always_comb begin
      adv[8] = !v_ff[8] || rsp_tready;
      for (int k = 7; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[1];
   assign rsp_tvalid = v_ff[8];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) begin
            v_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= 8; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Input unpacking.
   logic [Y-1:0]       year_in;
   logic [3:0]         month_in;
   logic [4:0]         day_in;
   logic [16:0]        second_in;
   logic signed [23:0] delta_days;
   logic signed [31:0] delta_seconds;
   echo_type           echo_in;

   assign year_in       = req_tdata[Y-1:0];
   assign month_in      = req_tdata[Y+3:Y];
   assign day_in        = req_tdata[Y+8:Y+4];
   assign second_in     = req_tdata[Y+25:Y+9];
   assign delta_days    = req_tdata[Y+49:Y+26];
   assign delta_seconds = req_tdata[Y+81:Y+50];
   assign echo_in       = '{year: year_in, month: month_in, day: day_in, sec: second_in};

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         echo_ff[1] <= echo_in;
      end
      for (int k = 2; k <= 8; k++) begin
         if (adv[k]) begin
            echo_ff[k] <= echo_ff[k-1];
         end
      end
   end

   // Stage 1: biased second sum.
   logic [3:0]         mon1_ff, mon1_in;
   logic signed [23:0] dd1_ff;
   logic [32:0]        u1_ff, u1_in;

   assign mon1_in = (month_in > 4'd11) ? 4'd11 : month_in;
   assign u1_in   = 33'(second_in) + 33'(signed'(delta_seconds)) + SEC_BIAS;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         mon1_ff <= mon1_in;
         dd1_ff  <= delta_days;
         u1_ff   <= u1_in;
      end
   end

   // Stage 2: day quotient estimate and days before the input year.
   logic [52:0]        qprod;
   logic [15:0]        q0_2_ff, q0_2_in;
   logic [DW-1:0]      days2_ff, days2_in;
   logic               leap2_ff, leap2_in;
   logic [3:0]         mon2_ff;
   logic signed [23:0] dd2_ff;
   logic [32:0]        u2_ff;

   assign qprod   = 53'(u1_ff[32:7]) * 53'(M675);
   assign q0_2_in = qprod[51:36];

   cdadv_year_days #(.YEAR_BITS(YEAR_BITS)) u_days_in (
      .kind (kind_ff),
      .year ({1'b0, echo_ff[1].year}),
      .days (days2_in),
      .leap (leap2_in)
   );

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         q0_2_ff  <= q0_2_in;
         days2_ff <= days2_in;
         leap2_ff <= leap2_in;
         mon2_ff  <= mon1_ff;
         dd2_ff   <= dd1_ff;
         u2_ff    <= u1_ff;
      end
   end

   // Stage 3: quotient correction and day number of the input date plus delta_days.
   logic [32:0]             rem0;
   logic                    carry;
   logic [15:0]             q3_ff, q3_in;
   logic [16:0]             r3_ff, r3_in;
   logic signed [ABS_W-1:0] base3_ff, base3_in;

   assign rem0     = u2_ff - 33'(q0_2_ff) * 33'(SECS_PER_DAY);
   assign carry    = rem0[17:0] >= 18'(SECS_PER_DAY);
   assign q3_in    = carry ? q0_2_ff + 16'd1 : q0_2_ff;
   assign r3_in    = carry ? 17'(rem0[17:0] - 18'(SECS_PER_DAY)) : rem0[16:0];
   assign base3_in = ABS_W'(days2_ff) + ABS_W'(month_offset(is360, leap2_ff, mon2_ff))
                   + ABS_W'(echo_ff[2].day) + ABS_W'(dd2_ff);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         q3_ff    <= q3_in;
         r3_ff    <= r3_in;
         base3_ff <= base3_in;
      end
   end

   // Stage 4: absolute day number.
   logic signed [ABS_W-1:0] abs4_ff, abs4_in;
   logic [16:0]             r4_ff;

   assign abs4_in = base3_ff + ABS_W'(q3_ff) - ABS_W'(SEC_OFFSET_DAYS);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         abs4_ff <= abs4_in;
         r4_ff   <= r3_ff;
      end
   end

   // Stage 5: range check and year estimate.
   logic [ABS_W-1:0]  end_sel;
   logic [RW-1:0]     rcp_sel;
   logic [DW+RW-1:0]  yprod;
   logic              oor5_ff, oor5_in;
   logic [Y:0]        y0_5_ff, y0_5_in;
   logic signed [ABS_W-1:0] abs5_ff;
   logic [16:0]       r5_ff;

   always_comb begin
      case (kind_ff)
         CAL_GREGORIAN: begin
            end_sel = END_GREG[ABS_W-1:0];
            rcp_sel = RCP_GREG[RW-1:0];
         end
         CAL_ALL_LEAP: begin
            end_sel = END_366[ABS_W-1:0];
            rcp_sel = RCP_366[RW-1:0];
         end
         CAL_360_DAY: begin
            end_sel = END_360[ABS_W-1:0];
            rcp_sel = RCP_360[RW-1:0];
         end
         CAL_JULIAN: begin
            end_sel = END_JUL[ABS_W-1:0];
            rcp_sel = RCP_JUL[RW-1:0];
         end
         default: begin
            end_sel = END_365[ABS_W-1:0];
            rcp_sel = RCP_365[RW-1:0];
         end
      endcase
   end

   assign yprod   = (DW+RW)'(abs4_ff[DW-1:0]) * (DW+RW)'(rcp_sel);
   assign y0_5_in = yprod[SH+Y:SH];
   assign oor5_in = abs4_ff[ABS_W-1] || ($unsigned(abs4_ff) >= end_sel);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         oor5_ff <= oor5_in;
         y0_5_ff <= y0_5_in;
         abs5_ff <= abs4_ff;
         r5_ff   <= r4_ff;
      end
   end

   // Stage 6: year start days around the estimate.
   logic [Y:0]      ym_5, yp_5;
   logic [DW-1:0]   dby0_in, dbym_in, dbyp_unused;
   logic            lp0_in, lpm_in, lpp_in;
   logic [DW-1:0]   dby0_ff, dbym_ff;
   logic            lp0_ff, lpm_ff, lpp_ff;
   logic            oor6_ff;
   logic [Y:0]      y0_6_ff;
   logic signed [ABS_W-1:0] abs6_ff;
   logic [16:0]     r6_ff;

   assign ym_5 = y0_5_ff - (Y+1)'(1);
   assign yp_5 = y0_5_ff + (Y+1)'(1);

   cdadv_year_days #(.YEAR_BITS(YEAR_BITS)) u_days_mid (
      .kind (kind_ff), .year (y0_5_ff), .days (dby0_in), .leap (lp0_in)
   );
   cdadv_year_days #(.YEAR_BITS(YEAR_BITS)) u_days_prev (
      .kind (kind_ff), .year (ym_5), .days (dbym_in), .leap (lpm_in)
   );
   cdadv_year_days #(.YEAR_BITS(YEAR_BITS)) u_days_next (
      .kind (kind_ff), .year (yp_5), .days (dbyp_unused), .leap (lpp_in)
   );

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         dby0_ff <= dby0_in;
         dbym_ff <= dbym_in;
         lp0_ff  <= lp0_in;
         lpm_ff  <= lpm_in;
         lpp_ff  <= lpp_in;
         oor6_ff <= oor5_ff;
         y0_6_ff <= y0_5_ff;
         abs6_ff <= abs5_ff;
         r6_ff   <= r5_ff;
      end
   end

   // Stage 7: year correction and day of year.
   logic signed [ABS_W-1:0] d0, dm, len0;
   logic [Y-1:0] y7_ff, y7_in;
   logic [8:0]   doy7_ff, doy7_in;
   logic         leap7_ff, leap7_in;
   logic         oor7_ff;
   logic [16:0]  r7_ff;

   assign d0   = abs6_ff - ABS_W'(dby0_ff);
   assign dm   = abs6_ff - ABS_W'(dbym_ff);
   assign len0 = is360 ? ABS_W'(360) : ABS_W'(365) + ABS_W'(lp0_ff);

   always_comb begin
      if (d0 < 0) begin
         y7_in    = Y'(y0_6_ff - (Y+1)'(1));
         doy7_in  = dm[8:0];
         leap7_in = lpm_ff;
      end else if (d0 >= len0) begin
         y7_in    = Y'(y0_6_ff + (Y+1)'(1));
         doy7_in  = 9'(d0 - len0);
         leap7_in = lpp_ff;
      end else begin
         y7_in    = y0_6_ff[Y-1:0];
         doy7_in  = d0[8:0];
         leap7_in = lp0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         y7_ff    <= y7_in;
         doy7_ff  <= doy7_in;
         leap7_ff <= leap7_in;
         oor7_ff  <= oor6_ff;
         r7_ff    <= r6_ff;
      end
   end

   // Stage 8: month split and response register.
   logic [3:0]       mon8;
   logic [4:0]       day8;
   logic [RSP_W-1:0] rsp_ff, rsp_in;
   logic             oor8_ff;

   cdadv_month_split u_month (
      .is360 (is360),
      .leap  (leap7_ff),
      .doy   (doy7_ff),
      .month (mon8),
      .day   (day8)
   );

   always_comb begin
      rsp_in = '0;
      if (oor7_ff) begin
         rsp_in[Y+25:0] = {echo_ff[7].sec, echo_ff[7].day, echo_ff[7].month,
                           echo_ff[7].year};
      end else begin
         rsp_in[Y+25:0] = {r7_ff, day8, mon8, y7_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         rsp_ff  <= rsp_in;
         oor8_ff <= oor7_ff;
      end
   end

   assign rsp_tdata = rsp_ff;
   assign rsp_tuser = oor8_ff;

endmodule
`default_nettype wire
